/* hdl/mm_pkg.sv */
// Shared types, constants and helpers for the matrix multiply block.
`default_nettype none

package mm_pkg;

    localparam int DIM_W     = 4;            // width of a dimension register
    localparam int SIZE_W    = 2 * DIM_W;    // width of a matrix element count
    localparam int IDX_W     = 3;            // row / column index width on the output
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_BITS = 8;            // Q8.8 fraction bits

    typedef logic [DIM_W-1:0] dim_t;

    localparam dim_t DIM_RESET = dim_t'(8);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

    // one job: effective sizes of the multiply
    typedef struct packed {
        dim_t nr;
        dim_t ni;
        dim_t nc;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ISSUE,
        BK_DRAIN
    } bk_state_t;

    // a zero size acts as one, a size past the maximum acts as the maximum
    function automatic dim_t eff_dim(dim_t v, dim_t max_dim);
        dim_t r;
        if (v == '0)
            r = dim_t'(1);
        else if (v > max_dim)
            r = max_dim;
        else
            r = v;
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/mm_job_fifo.sv */
// Two-entry job queue between the load front end and the compute back end.
`default_nettype none

module mm_job_fifo (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire mm_pkg::job_t push_job,
    output logic             full,
    input  wire logic        pop,
    output mm_pkg::job_t     pop_job,
    output logic             not_empty
);
    import mm_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_job   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hdl/mm_front.sv */
// Load front end: size registers, element counters, store writes and job detection.
`default_nettype none

module mm_front #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16,
    parameter int ADDR_W     = 6,
    parameter int CNT_W      = 7
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [mm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mm_pkg::DIM_W-1:0]      cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          in_mode,
    input  wire logic [ELEM_WIDTH-1:0]         in_element,
    input  wire logic                          job_busy,
    input  wire logic                          job_full,
    output logic                               job_push,
    output mm_pkg::job_t                       job,
    output logic                               wr_a,
    output logic                               wr_b,
    output logic [ADDR_W-1:0]                  wr_addr,
    output logic [ELEM_WIDTH-1:0]              wr_data
);
    import mm_pkg::*;

    localparam dim_t MAX_D = dim_t'(MAX_DIM);

    dim_t             rows_a_reg;
    dim_t             inner_dim_reg;
    dim_t             cols_b_reg;
    logic [CNT_W-1:0] count_a_reg;
    logic [CNT_W-1:0] count_b_reg;

    logic              accept;
    dim_t              nr, ni, nc;
    logic [SIZE_W-1:0] size_a, size_b;
    logic [CNT_W-1:0]  count_a_next, count_b_next;
    logic              done;

    always_comb
    begin
        nr     = eff_dim(rows_a_reg, MAX_D);
        ni     = eff_dim(inner_dim_reg, MAX_D);
        nc     = eff_dim(cols_b_reg, MAX_D);
        size_a = SIZE_W'(nr) * SIZE_W'(ni);
        size_b = SIZE_W'(ni) * SIZE_W'(nc);

        in_ready = !job_busy && !job_full;
        accept   = in_valid && in_ready;

        // full matrices drop further loads
        wr_a = accept && !in_mode && (SIZE_W'(count_a_reg) < size_a);
        wr_b = accept &&  in_mode && (SIZE_W'(count_b_reg) < size_b);
        wr_addr = in_mode ? count_b_reg[ADDR_W-1:0] : count_a_reg[ADDR_W-1:0];
        wr_data = in_element;

        count_a_next = count_a_reg + CNT_W'(wr_a);
        count_b_next = count_b_reg + CNT_W'(wr_b);

        done = accept && (SIZE_W'(count_a_next) >= size_a)
                      && (SIZE_W'(count_b_next) >= size_b);

        job_push = done;
        job.nr   = nr;
        job.ni   = ni;
        job.nc   = nc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= DIM_RESET;
            inner_dim_reg <= DIM_RESET;
            cols_b_reg    <= DIM_RESET;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_ROWS_A)
                    rows_a_reg <= cfg_data;
                if (cfg_index == REG_INNER_DIM)
                    inner_dim_reg <= cfg_data;
                if (cfg_index == REG_COLS_B)
                    cols_b_reg <= cfg_data;
            end
            if (accept)
            begin
                count_a_reg <= done ? '0 : count_a_next;
                count_b_reg <= done ? '0 : count_b_next;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/mm_back.sv */
// Compute back end: element stores, dot-product sequencer, MAC pipeline, result register.
`default_nettype none

module mm_back #(
    parameter int SLOTS      = 64,
    parameter int ADDR_W     = 6,
    parameter int ELEM_WIDTH = 16,
    parameter int ACC_W      = 36
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         wr_a,
    input  wire logic                         wr_b,
    input  wire logic [ADDR_W-1:0]            wr_addr,
    input  wire logic [ELEM_WIDTH-1:0]        wr_data,
    input  wire logic                         job_valid,
    input  wire mm_pkg::job_t                 job,
    output logic                              job_pop,
    output logic                              busy,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [ELEM_WIDTH-1:0]             out_product,
    output logic [mm_pkg::IDX_W-1:0]          out_row,
    output logic [mm_pkg::IDX_W-1:0]          out_col,
    output logic                              out_last
);
    import mm_pkg::*;

    localparam logic signed [ACC_W-1:0] SAT_HI =
        ACC_W'((64'sd1 <<< (ELEM_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    logic [ELEM_WIDTH-1:0] mem_a [SLOTS];
    logic [ELEM_WIDTH-1:0] mem_b [SLOTS];

    bk_state_t   state_reg, state_next;
    job_t        job_reg;
    dim_t        r_reg, c_reg, n_reg;
    logic [ADDR_W-1:0] a_base_reg, a_ptr_reg, b_ptr_reg;

    logic signed [ELEM_WIDTH-1:0]   rd_a_reg, rd_b_reg;
    logic signed [2*ELEM_WIDTH-1:0] mul_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic v1_reg, first1_reg, last1_reg;
    logic v2_reg, first2_reg, last2_reg;
    logic done3_reg;
    logic out_valid_reg;

    logic issue_fire;
    logic out_free;
    logic n_last;
    logic c_last;
    logic last_elem;
    logic advance;
    logic signed [ACC_W-1:0]      shifted;
    logic        [ELEM_WIDTH-1:0] sat;

    assign out_free  = !out_valid_reg || out_ready;
    assign n_last    = (n_reg == job_reg.ni - dim_t'(1));
    assign c_last    = (c_reg == job_reg.nc - dim_t'(1));
    assign last_elem = (r_reg == job_reg.nr - dim_t'(1)) && c_last;
    assign busy      = (state_reg != BK_IDLE);
    assign out_valid = out_valid_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        job_pop    = 1'b0;
        issue_fire = 1'b0;
        advance    = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    state_next = BK_ISSUE;
                end
            end
            BK_ISSUE:
            begin
                // a new dot product starts only once the result register is free
                if (n_reg != '0 || out_free)
                begin
                    issue_fire = 1'b1;
                    if (n_last)
                        state_next = BK_DRAIN;
                end
            end
            BK_DRAIN:
            begin
                if (done3_reg)
                begin
                    advance    = 1'b1;
                    state_next = last_elem ? BK_IDLE : BK_ISSUE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            job_reg    <= '0;
            r_reg      <= '0;
            c_reg      <= '0;
            n_reg      <= '0;
            a_base_reg <= '0;
            a_ptr_reg  <= '0;
            b_ptr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (job_pop)
            begin
                job_reg    <= job;
                r_reg      <= '0;
                c_reg      <= '0;
                n_reg      <= '0;
                a_base_reg <= '0;
                a_ptr_reg  <= '0;
                b_ptr_reg  <= '0;
            end
            else if (issue_fire)
            begin
                n_reg     <= n_last ? '0 : n_reg + dim_t'(1);
                a_ptr_reg <= a_ptr_reg + ADDR_W'(1);
                b_ptr_reg <= b_ptr_reg + ADDR_W'(job_reg.nc);
            end
            else if (advance && !last_elem)
            begin
                if (c_last)
                begin
                    c_reg      <= '0;
                    r_reg      <= r_reg + dim_t'(1);
                    a_base_reg <= a_base_reg + ADDR_W'(job_reg.ni);
                    a_ptr_reg  <= a_base_reg + ADDR_W'(job_reg.ni);
                    b_ptr_reg  <= '0;
                end
                else
                begin
                    c_reg     <= c_reg + dim_t'(1);
                    a_ptr_reg <= a_base_reg;
                    b_ptr_reg <= ADDR_W'(c_reg + dim_t'(1));
                end
            end
        end
    end

    // stores: one write port from the front end, one registered read port each
    always_ff @(posedge clk)
    begin
        if (wr_a)
            mem_a[wr_addr] <= wr_data;
        if (wr_b)
            mem_b[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        rd_a_reg <= mem_a[a_ptr_reg];
        rd_b_reg <= mem_b[b_ptr_reg];
    end

    // multiply and accumulate
    always_ff @(posedge clk)
    begin
        first1_reg <= (n_reg == '0);
        last1_reg  <= n_last;
        mul_reg    <= rd_a_reg * rd_b_reg;
        first2_reg <= first1_reg;
        last2_reg  <= last1_reg;
        if (v2_reg)
            acc_reg <= first2_reg ? ACC_W'(mul_reg) : acc_reg + ACC_W'(mul_reg);
    end

    always_comb
    begin
        shifted = acc_reg >>> FRAC_BITS;
        if (shifted > SAT_HI)
            sat = SAT_HI[ELEM_WIDTH-1:0];
        else if (shifted < SAT_LO)
            sat = SAT_LO[ELEM_WIDTH-1:0];
        else
            sat = shifted[ELEM_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (done3_reg)
        begin
            out_product <= sat;
            out_row     <= r_reg[IDX_W-1:0];
            out_col     <= c_reg[IDX_W-1:0];
            out_last    <= last_elem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            done3_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg    <= issue_fire;
            v2_reg    <= v1_reg;
            done3_reg <= v2_reg && last2_reg;
            if (done3_reg)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // a finished sum never lands on a result that is still waiting
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done3_reg |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before transfer");

    a_n_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_ISSUE) |-> (n_reg < job_reg.ni))
        else $error("inner index out of range");

    a_rc_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BK_IDLE) |-> (r_reg < job_reg.nr && c_reg < job_reg.nc))
        else $error("row or column index out of range");

    a_one_dot: assert property (@(posedge clk) disable iff (!rst_n)
        issue_fire && (n_reg == '0) |-> !v1_reg && !v2_reg && !done3_reg)
        else $error("dot product started while another is in flight");

endmodule

`default_nettype wire

/* hdl/matrix_multiply.sv */
// Top level of the signed Q8.8 matrix multiply block.
//
// Matrix A (rows_a x inner_dim) and matrix B (inner_dim x cols_b) are
// loaded one element per input transfer in row-major order; s_tuser selects
// the matrix (0 = A, 1 = B). Elements beyond a full matrix are dropped. The
// transfer after which both matrices are complete starts a job, and the
// block then streams every C[row][col] in row-major order, m_tlast on the
// final one, with sums formed exactly, shifted right by 8 and saturated.
// Sizes of 0 act as 1 and sizes above MAX_DIM act as MAX_DIM. Each result
// comes from a single shared multiply-accumulate fed by one read port per
// store, through registered read, multiply and accumulate steps before the
// saturated sum lands in the output register; s_tready stays low from the
// completing transfer until the last result has been written to the output
// register. No clearing pass is needed after reset.
// Write the size registers only while idle.
`default_nettype none

module matrix_multiply #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // configuration write port
    input  wire logic                                 cfg_we,
    input  wire logic [mm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [mm_pkg::DIM_W-1:0]             cfg_data,
    // element input
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [((ELEM_WIDTH+7)/8)*8-1:0]      s_tdata,  // element
    input  wire logic                                 s_tuser,  // mode
    // result output
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [((ELEM_WIDTH+6+7)/8)*8-1:0]         m_tdata,  // product, row, col
    output logic                                      m_tlast
);
    import mm_pkg::*;

    localparam int SLOTS  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int ACC_W  = 2 * ELEM_WIDTH + $clog2(MAX_DIM) + 1;
    localparam int OUT_W  = ((ELEM_WIDTH + 6 + 7) / 8) * 8;

    logic                  job_push, job_full, job_not_empty, job_pop, back_busy;
    job_t                  front_job, queued_job;
    logic                  wr_a, wr_b;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ELEM_WIDTH-1:0] wr_data;
    logic [ELEM_WIDTH-1:0] out_product;
    logic [IDX_W-1:0]      out_row, out_col;

    // front end holds off loads while any job is queued or running
    mm_front #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH),
        .ADDR_W     (ADDR_W),
        .CNT_W      (CNT_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_mode    (s_tuser),
        .in_element (s_tdata[ELEM_WIDTH-1:0]),
        .job_busy   (job_not_empty || back_busy),
        .job_full   (job_full),
        .job_push   (job_push),
        .job        (front_job),
        .wr_a       (wr_a),
        .wr_b       (wr_b),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    mm_job_fifo u_job_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_job  (front_job),
        .full      (job_full),
        .pop       (job_pop),
        .pop_job   (queued_job),
        .not_empty (job_not_empty)
    );

    mm_back #(
        .SLOTS      (SLOTS),
        .ADDR_W     (ADDR_W),
        .ELEM_WIDTH (ELEM_WIDTH),
        .ACC_W      (ACC_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_a        (wr_a),
        .wr_b        (wr_b),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .job_valid   (job_not_empty),
        .job         (queued_job),
        .job_pop     (job_pop),
        .busy        (back_busy),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_product (out_product),
        .out_row     (out_row),
        .out_col     (out_col),
        .out_last    (m_tlast)
    );

    // tdata packing from bit 0: product, row, col, zero fill
    assign m_tdata = OUT_W'({out_col, out_row, out_product});

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Testbench for the Q8.8 matrix multiply block: predicted products checked per transfer.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mm_pkg::*;

    localparam int MAX_DIM       = 8;
    localparam int ELEM_W        = 16;
    localparam int SLOTS         = MAX_DIM * MAX_DIM;
    localparam int S_DATA_W      = ((ELEM_W + 7) / 8) * 8;
    localparam int M_DATA_W      = ((ELEM_W + 6 + 7) / 8) * 8;
    localparam int RANDOM_ITEMS  = 500;  // stored loads in the random part
    localparam int SETTLE_CYCLES = 16;   // quiet time before a size write
    localparam int DRAIN_CYCLES  = 64;   // quiet time before the verdict
    localparam int STALL_LIMIT   = 2000; // cycles without any transfer

    // s_tuser values
    localparam bit MODE_A = 1'b0;
    localparam bit MODE_B = 1'b1;

    localparam longint Q_MAX = (longint'(1) <<< (ELEM_W - 1)) - 1;
    localparam longint Q_MIN = -Q_MAX - 1;

    typedef logic signed [ELEM_W-1:0] q88_t;

    // one element of C as it should leave the block
    typedef struct {
        q88_t             product;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } c_elem_t;

    // Mirrors the block: size registers, both element stores and load counters.
    // Every load that completes A and B pushes the whole of C, row-major.
    class product_tracker;
        dim_t    rows_reg;
        dim_t    inner_reg;
        dim_t    cols_reg;
        q88_t    a_mem [SLOTS];
        q88_t    b_mem [SLOTS];
        int      a_cnt;
        int      b_cnt;
        c_elem_t c_pending [$];
        int      errors;

        function new();
            rows_reg  = DIM_RESET;
            inner_reg = DIM_RESET;
            cols_reg  = DIM_RESET;
            a_cnt     = 0;
            b_cnt     = 0;
            errors    = 0;
        endfunction

        function void set_size(logic [CFG_IDX_W-1:0] idx, dim_t v);
            case (idx)
                REG_ROWS_A:    rows_reg  = v;
                REG_INNER_DIM: inner_reg = v;
                REG_COLS_B:    cols_reg  = v;
                default: ;
            endcase
        endfunction

        // zero behaves as one, anything past MAX_DIM as MAX_DIM
        function int clamp_dim(dim_t v);
            int d;
            if (v == '0)
                d = 1;
            else if (v > MAX_DIM)
                d = MAX_DIM;
            else
                d = int'(v);
            return d;
        endfunction

        function int a_size();
            return clamp_dim(rows_reg) * clamp_dim(inner_reg);
        endfunction

        function int b_size();
            return clamp_dim(inner_reg) * clamp_dim(cols_reg);
        endfunction

        // returns the number of C elements this load released
        function int note_element(bit mode, q88_t value);
            int      nr;
            int      ni;
            int      nc;
            longint  acc;
            c_elem_t c;
            nr = clamp_dim(rows_reg);
            ni = clamp_dim(inner_reg);
            nc = clamp_dim(cols_reg);
            if (mode == MODE_A) begin
                if (a_cnt < nr * ni) begin
                    a_mem[a_cnt] = value;
                    a_cnt++;
                end
            end
            else begin
                if (b_cnt < ni * nc) begin
                    b_mem[b_cnt] = value;
                    b_cnt++;
                end
            end
            // counts are compared against the current sizes, so a shrink
            // completes the job on the next load of either matrix
            if (a_cnt < nr * ni || b_cnt < ni * nc)
                return 0;
            for (int r = 0; r < nr; r++) begin
                for (int k = 0; k < nc; k++) begin
                    acc = 0;
                    for (int n = 0; n < ni; n++)
                        acc += longint'(a_mem[r * ni + n]) * longint'(b_mem[n * nc + k]);
                    acc = acc >>> FRAC_BITS;
                    if (acc > Q_MAX)
                        acc = Q_MAX;
                    else if (acc < Q_MIN)
                        acc = Q_MIN;
                    c.product = q88_t'(acc);
                    c.row     = IDX_W'(r);
                    c.col     = IDX_W'(k);
                    c.last    = (r == nr - 1) && (k == nc - 1);
                    c_pending.push_back(c);
                end
            end
            a_cnt = 0;
            b_cnt = 0;
            return nr * nc;
        endfunction

        function void check_result(q88_t product, logic [IDX_W-1:0] row,
                                   logic [IDX_W-1:0] col, logic last);
            c_elem_t want;
            if (c_pending.size() == 0) begin
                $error("unexpected result: product %0d row %0d col %0d last %0b",
                       product, row, col, last);
                errors++;
                return;
            end
            want = c_pending.pop_front();
            if (product !== want.product) begin
                $error("product: expected %0d, actual %0d", want.product, product);
                errors++;
            end
            if (row !== want.row) begin
                $error("row: expected %0d, actual %0d", want.row, row);
                errors++;
            end
            if (col !== want.col) begin
                $error("col: expected %0d, actual %0d", want.col, col);
                errors++;
            end
            if (last !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return c_pending.size();
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [DIM_W-1:0]      cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;  // element
    logic                  s_tuser   = 1'b0; // mode
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;         // product, row, col
    logic                  m_tlast;

    // percentage of cycles in which the sender idles / the receiver stalls
    int send_idle  = 0;
    int recv_stall = 0;

    product_tracker gemm;

    matrix_multiply #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // low half first, so the first rising edge is at 4 ns
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Result side: random backpressure, every transfer goes to the tracker.
    // Sampled in the active region, so DUT flops still show pre-edge values.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall);
        if (m_tvalid && m_tready)
            gemm.check_result(m_tdata[ELEM_W-1:0],
                              m_tdata[ELEM_W+IDX_W-1:ELEM_W],
                              m_tdata[ELEM_W+2*IDX_W-1:ELEM_W+IDX_W],
                              m_tlast);
    end

    // Watchdog: any transfer or size write counts as progress.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    // Idle mix per job: none, sender only, receiver only, both.
    task automatic set_phase(int k);
        case (k % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 52; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 52; end
            default: begin send_idle = 36; recv_stall = 36; end
        endcase
    endtask

    // One size write; we drops in a step of its own so back-to-back calls
    // never raise and lower it in the same step.
    task automatic write_size(logic [CFG_IDX_W-1:0] idx, dim_t v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        gemm.set_size(idx, v);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one element after a random idle stretch and waits for the transfer.
    task automatic send_element(bit mode, q88_t value, output int released);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= S_DATA_W'($unsigned(value));
        do
            @(posedge clk);
        while (!s_tready);
        released = gemm.note_element(mode, value);
    endtask

    // Block idle: every result in, then a margin for any load still in flight.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (gemm.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic q88_t pick_value();
        int   sel;
        q88_t v;
        sel = $urandom_range(99);
        if (sel < 10) begin
            case ($urandom_range(5))
                0: v = q88_t'(Q_MIN);
                1: v = q88_t'(Q_MAX);
                2: v = '0;
                3: v = -q88_t'(1);
                4: v = q88_t'(256);   // 1.0
                default: v = -q88_t'(256);
            endcase
        end
        else if (sel < 40)
            v = q88_t'($urandom);
        else
            v = q88_t'($urandom_range(1023)) - q88_t'(512);  // within +-2.0
        return v;
    endfunction

    // Mostly small sizes; zero and out-of-range values now and then.
    function automatic dim_t pick_dim();
        int   sel;
        dim_t d;
        sel = $urandom_range(99);
        if (sel < 8)
            d = '0;
        else if (sel < 16)
            d = dim_t'($urandom_range(15, MAX_DIM + 1));
        else if (sel < 24)
            d = dim_t'(MAX_DIM);
        else
            d = dim_t'($urandom_range(4, 1));
        return d;
    endfunction

    // Sets the sizes, then loads random elements until C is released.
    // A few loads land on an already full matrix and are dropped.
    task automatic run_random_job(dim_t nr, dim_t ni, dim_t nc, inout int stored);
        int released;
        int a_need;
        int b_need;
        bit mode;
        write_size(REG_ROWS_A, nr);
        write_size(REG_INNER_DIM, ni);
        write_size(REG_COLS_B, nc);
        a_need   = gemm.a_size();
        b_need   = gemm.b_size();
        released = 0;
        while (released == 0) begin
            if ($urandom_range(99) < 8)
                mode = bit'($urandom_range(1));
            else if (gemm.a_cnt >= a_need)
                mode = MODE_B;
            else if (gemm.b_cnt >= b_need)
                mode = MODE_A;
            else
                mode = bit'($urandom_range(1));
            if ((mode == MODE_A && gemm.a_cnt < a_need) ||
                (mode == MODE_B && gemm.b_cnt < b_need))
                stored++;
            send_element(mode, pick_value(), released);
        end
        settle();
    endtask

    initial
    begin
        int job;
        int stored;
        int released;
        gemm = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero sizes act as 1x1x1; a second A load is dropped; the single
        // product overflows and saturates high.
        set_phase(0);
        write_size(REG_ROWS_A, '0);
        write_size(REG_INNER_DIM, '0);
        write_size(REG_COLS_B, '0);
        send_element(MODE_A, q88_t'(Q_MAX), released);
        send_element(MODE_A, -q88_t'(1), released);
        send_element(MODE_B, q88_t'(Q_MAX), released);
        settle();

        // 2x1 by 1x1, B loaded first: negative saturation and exact 32767,
        // plus an excess B load.
        set_phase(1);
        write_size(REG_ROWS_A, dim_t'(2));
        write_size(REG_INNER_DIM, dim_t'(1));
        write_size(REG_COLS_B, dim_t'(1));
        send_element(MODE_B, q88_t'(Q_MAX), released);
        send_element(MODE_B, q88_t'(5), released);
        send_element(MODE_A, q88_t'(Q_MIN), released);
        send_element(MODE_A, q88_t'(256), released);
        settle();

        // 1x2 by 2x3 with interleaved loads: small fractions, rounding of
        // negative sums toward minus infinity, mixed signs.
        set_phase(2);
        write_size(REG_ROWS_A, dim_t'(1));
        write_size(REG_INNER_DIM, dim_t'(2));
        write_size(REG_COLS_B, dim_t'(3));
        send_element(MODE_B, q88_t'(1), released);
        send_element(MODE_A, -q88_t'(1), released);
        send_element(MODE_B, q88_t'(Q_MIN), released);
        send_element(MODE_B, '0, released);
        send_element(MODE_A, q88_t'(1), released);
        send_element(MODE_B, -q88_t'(1), released);
        send_element(MODE_B, q88_t'(255), released);
        send_element(MODE_B, q88_t'(Q_MAX), released);
        settle();

        // Shrink while loading: 2x2x2 with B one short, then cols_b drops to
        // 1 so B is already full; the next load, a dropped A, ends the job.
        set_phase(3);
        write_size(REG_ROWS_A, dim_t'(2));
        write_size(REG_INNER_DIM, dim_t'(2));
        write_size(REG_COLS_B, dim_t'(2));
        send_element(MODE_A, q88_t'(384), released);
        send_element(MODE_A, -q88_t'(640), released);
        send_element(MODE_A, q88_t'(12345), released);
        send_element(MODE_A, -q88_t'(7), released);
        send_element(MODE_B, q88_t'(512), released);
        send_element(MODE_B, -q88_t'(300), released);
        send_element(MODE_B, q88_t'(1000), released);
        settle();
        write_size(REG_COLS_B, dim_t'(1));
        send_element(MODE_A, q88_t'(99), released);
        settle();

        // Random jobs: the two largest first (out-of-range 15 and exact 8),
        // then mostly small sizes, idle mix rotating per job.
        job    = 4;
        stored = 0;
        while (stored < RANDOM_ITEMS) begin
            set_phase(job);
            if (job == 4)
                run_random_job(dim_t'(15), dim_t'(15), dim_t'(15), stored);
            else if (job == 5)
                run_random_job(dim_t'(MAX_DIM), dim_t'(MAX_DIM), dim_t'(MAX_DIM), stored);
            else
                run_random_job(pick_dim(), pick_dim(), pick_dim(), stored);
            job++;
        end

        // nothing pending after settle; keep the receiver open for strays
        recv_stall = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (gemm.errors == 0 && gemm.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
